// ----- design/rwlm_pkg.sv -----
package rwlm_pkg;

   // sizing of the lock counters and the requester id space
   localparam int unsigned MAX_READERS     = 255;
   localparam int unsigned MAX_DEPTH       = 255;
   localparam int unsigned REQUESTER_COUNT = 256;

   localparam logic [7:0] READER_CAP = (MAX_READERS < 255) ? 8'(MAX_READERS) : 8'd255;
   localparam logic [7:0] DEPTH_CAP  = (MAX_DEPTH < 255) ? 8'(MAX_DEPTH) : 8'd255;

   // operation codes
   localparam logic [3:0] OP_WRITE       = 4'd0;
   localparam logic [3:0] OP_READ        = 4'd1;
   localparam logic [3:0] OP_DONE        = 4'd2;
   localparam logic [3:0] OP_UPGRADE     = 4'd3;
   localparam logic [3:0] OP_DOWNGRADE   = 4'd4;
   localparam logic [3:0] OP_TRY_WRITE   = 4'd5;
   localparam logic [3:0] OP_TRY_READ    = 4'd6;
   localparam logic [3:0] OP_TRY_UPGRADE = 4'd7;
   localparam logic [3:0] OP_SET_REC     = 4'd8;
   localparam logic [3:0] OP_CLEAR_REC   = 4'd9;
   localparam logic [3:0] OP_QUERY       = 4'd10;

   // status codes
   localparam logic [1:0] ST_GRANTED = 2'd0;
   localparam logic [1:0] ST_WAIT    = 2'd1;
   localparam logic [1:0] ST_FAILED  = 2'd2;
   localparam logic [1:0] ST_ERROR   = 2'd3;

   typedef struct packed {
      logic [3:0] operation;
      logic [7:0] requester;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       wake;
      logic [7:0] readers_now;
      logic       write_claimed;
      logic       upgrade_claimed;
      logic [7:0] depth_now;
      logic       owner_bound;
   } rsp_payload_type;

endpackage

// ----- design/reader_writer_lock_manager.sv -----
// Reader-writer lock manager: keeps one lock with a write claim, an upgrade claim, a
// reader count, a recursion depth and an optional recursive owner. Each request carries
// an operation and a requester id and produces exactly one response with a status
// (granted, must_wait, failed or error), a wake flag and a snapshot of the lock state
// after the request. A request that would block in software instead marks waiters and
// answers must_wait; the requester polls with query. The block sustains one request per
// clock while responses are taken: a request is captured in an input register, and once
// the response register is free or draining, one combinational pass updates the lock
// state and loads the response register. The input register keeps accepting while a
// response is stalled, until both stages are full; the single state-update pass is what
// sets the one-per-cycle figure.
module reader_writer_lock_manager
   import rwlm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // input stage
   logic            in_valid_ff;
   req_payload_type in_ff;

   // response stage
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;

   // lock state
   logic       write_flag_ff,      write_flag_in;
   logic       upgrade_flag_ff,    upgrade_flag_in;
   logic [7:0] reader_count_ff,    reader_count_in;
   logic [7:0] recursion_count_ff, recursion_count_in;
   logic [7:0] owner_id_ff,        owner_id_in;
   logic       owner_valid_ff,     owner_valid_in;
   logic       waiters_ff,         waiters_in;

   logic       advance;
   logic       is_owner;
   logic [1:0] status;
   logic       wake;

   // a request moves on when the response slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign is_owner  = owner_valid_ff && (owner_id_ff == in_ff.requester);

   always_comb begin
      write_flag_in      = write_flag_ff;
      upgrade_flag_in    = upgrade_flag_ff;
      reader_count_in    = reader_count_ff;
      recursion_count_in = recursion_count_ff;
      owner_id_in        = owner_id_ff;
      owner_valid_in     = owner_valid_ff;
      waiters_in         = waiters_ff;
      status             = ST_GRANTED;
      wake               = 1'b0;

      if (32'(in_ff.requester) >= REQUESTER_COUNT) begin
         status = ST_ERROR;
      end else begin
         case (in_ff.operation)
            OP_WRITE: begin
               if (is_owner) begin
                  if (recursion_count_ff < DEPTH_CAP)
                     recursion_count_in = recursion_count_ff + 8'd1;
               end else if (write_flag_ff) begin
                  waiters_in = 1'b1;
                  status     = ST_WAIT;
               end else begin
                  // claim is kept while readers or an upgrade drain
                  write_flag_in = 1'b1;
                  if (reader_count_ff != 8'd0 || upgrade_flag_ff) begin
                     waiters_in = 1'b1;
                     status     = ST_WAIT;
                  end
               end
            end
            OP_READ: begin
               if (!is_owner && (write_flag_ff || upgrade_flag_ff)) begin
                  waiters_in = 1'b1;
                  status     = ST_WAIT;
               end else if (reader_count_ff < READER_CAP) begin
                  reader_count_in = reader_count_ff + 8'd1;
               end
            end
            OP_DONE: begin
               if (reader_count_ff != 8'd0)
                  reader_count_in = reader_count_ff - 8'd1;
               else if (recursion_count_ff != 8'd0)
                  recursion_count_in = recursion_count_ff - 8'd1;
               else if (upgrade_flag_ff)
                  upgrade_flag_in = 1'b0;
               else
                  write_flag_in = 1'b0;
               wake       = waiters_ff;
               waiters_in = 1'b0;
            end
            OP_UPGRADE: begin
               // the read lock is dropped first in every case
               if (reader_count_ff != 8'd0)
                  reader_count_in = reader_count_ff - 8'd1;
               if (is_owner) begin
                  if (recursion_count_ff < DEPTH_CAP)
                     recursion_count_in = recursion_count_ff + 8'd1;
               end else if (upgrade_flag_ff) begin
                  wake       = waiters_ff;
                  waiters_in = 1'b0;
                  status     = ST_FAILED;
               end else begin
                  upgrade_flag_in = 1'b1;
                  if (reader_count_in != 8'd0) begin
                     waiters_in = 1'b1;
                     status     = ST_WAIT;
                  end
               end
            end
            OP_DOWNGRADE: begin
               if (reader_count_ff < READER_CAP)
                  reader_count_in = reader_count_ff + 8'd1;
               if (recursion_count_ff != 8'd0)
                  recursion_count_in = recursion_count_ff - 8'd1;
               else if (upgrade_flag_ff)
                  upgrade_flag_in = 1'b0;
               else
                  write_flag_in = 1'b0;
               wake       = waiters_ff;
               waiters_in = 1'b0;
            end
            OP_TRY_WRITE: begin
               if (is_owner) begin
                  if (recursion_count_ff < DEPTH_CAP)
                     recursion_count_in = recursion_count_ff + 8'd1;
               end else if (write_flag_ff || upgrade_flag_ff || reader_count_ff != 8'd0) begin
                  status = ST_FAILED;
               end else begin
                  write_flag_in = 1'b1;
               end
            end
            OP_TRY_READ: begin
               if (!is_owner && (write_flag_ff || upgrade_flag_ff))
                  status = ST_FAILED;
               else if (reader_count_ff < READER_CAP)
                  reader_count_in = reader_count_ff + 8'd1;
            end
            OP_TRY_UPGRADE: begin
               if (is_owner) begin
                  if (reader_count_ff != 8'd0)
                     reader_count_in = reader_count_ff - 8'd1;
                  if (recursion_count_ff < DEPTH_CAP)
                     recursion_count_in = recursion_count_ff + 8'd1;
               end else if (upgrade_flag_ff) begin
                  status = ST_FAILED;
               end else begin
                  upgrade_flag_in = 1'b1;
                  if (reader_count_ff != 8'd0)
                     reader_count_in = reader_count_ff - 8'd1;
                  if (reader_count_in != 8'd0) begin
                     waiters_in = 1'b1;
                     status     = ST_WAIT;
                  end
               end
            end
            OP_SET_REC: begin
               // binding needs a write claim and no other bound owner
               if (!write_flag_ff ||
                   (owner_valid_ff && owner_id_ff != in_ff.requester)) begin
                  status = ST_ERROR;
               end else begin
                  owner_id_in    = in_ff.requester;
                  owner_valid_in = 1'b1;
               end
            end
            OP_CLEAR_REC: begin
               if (!is_owner)
                  status = ST_ERROR;
               else if (recursion_count_ff == 8'd0)
                  owner_valid_in = 1'b0;
            end
            OP_QUERY: begin
               status = ST_GRANTED;
            end
            default: begin
               status = ST_ERROR;
            end
         endcase
      end

      out_in.status          = status;
      out_in.wake            = wake;
      out_in.readers_now     = reader_count_in;
      out_in.write_claimed   = write_flag_in;
      out_in.upgrade_claimed = upgrade_flag_in;
      out_in.depth_now       = recursion_count_in;
      out_in.owner_bound     = owner_valid_in;
   end

   // control and lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         write_flag_ff      <= 1'b0;
         upgrade_flag_ff    <= 1'b0;
         reader_count_ff    <= 8'd0;
         recursion_count_ff <= 8'd0;
         owner_id_ff        <= 8'd0;
         owner_valid_ff     <= 1'b0;
         waiters_ff         <= 1'b0;
      end else begin
         if (req_ready)
            in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff       <= 1'b1;
            write_flag_ff      <= write_flag_in;
            upgrade_flag_ff    <= upgrade_flag_in;
            reader_count_ff    <= reader_count_in;
            recursion_count_ff <= recursion_count_in;
            owner_id_ff        <= owner_id_in;
            owner_valid_ff     <= owner_valid_in;
            waiters_ff         <= waiters_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid)
         in_ff <= req_payload;
      if (advance)
         out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // a pending response always mirrors the current lock state
   a_rsp_mirrors_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.readers_now == reader_count_ff &&
                        out_ff.depth_now == recursion_count_ff &&
                        out_ff.write_claimed == write_flag_ff &&
                        out_ff.upgrade_claimed == upgrade_flag_ff &&
                        out_ff.owner_bound == owner_valid_ff))
      else $error("response snapshot differs from lock state");

   // binding an owner only happens under a write claim
   a_bind_needs_write: assert property (@(posedge clock) disable iff (reset)
      $rose(owner_valid_ff) |-> $past(write_flag_ff))
      else $error("recursive owner bound without write claim");

   // nonzero depth keeps the owner binding
   a_depth_keeps_owner: assert property (@(posedge clock) disable iff (reset)
      recursion_count_ff != 8'd0 |-> owner_valid_ff)
      else $error("recursion depth without bound owner");

   // a reported wake consumes the waiting mark
   a_wake_clears_mark: assert property (@(posedge clock) disable iff (reset)
      (advance && out_in.wake) |=> !waiters_ff)
      else $error("waiting mark survived a wake");

   // reader count stays within its cap
   a_reader_cap: assert property (@(posedge clock) disable iff (reset)
      reader_count_ff <= READER_CAP)
      else $error("reader count above cap");

endmodule
